// ----- src/dpa_pkg.sv -----
// shared widths, register indexes and constants of the doppler pitch and attenuation block
package dpa_pkg;

    localparam int POS_W    = 24;
    localparam int VEL_W    = 19;
    localparam int D_W      = POS_W + 1;
    localparam int DIST2_W  = 2 * D_W;
    localparam int DIST_W   = D_W;
    localparam int DOT_W    = 45;
    localparam int NUM_W    = 47;
    localparam int DIV_N_W  = 61;
    localparam int DIV_D_W  = 46;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 27;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    localparam int E_W      = 32;
    localparam int Q16_W    = 16;
    localparam int SPEED_W  = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPEED_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOPPLER_ENABLE    = 2'd0,
        CFG_DOPPLER_SCALE     = 2'd1,
        CFG_SOUND_SPEED       = 2'd2,
        CFG_ATTENUATION_SCALE = 2'd3
    } t_cfg_idx;

    localparam logic [Q16_W-1:0]   RST_DOPPLER_SCALE     = 16'd4096;
    localparam logic [SPEED_W-1:0] RST_SOUND_SPEED       = 20'd34300;
    localparam logic [Q16_W-1:0]   RST_ATTENUATION_SCALE = 16'd4096;

    localparam logic [Q16_W-1:0] PITCH_ONE  = 16'd16384;
    localparam logic [Q16_W-1:0] PITCH_MIN  = 16'd8192;
    localparam logic [Q16_W-1:0] PITCH_MAX  = 16'd32768;
    localparam logic [Q16_W-1:0] GAIN_ONE   = 16'd32768;

endpackage

// ----- src/dpa_mul.sv -----
// shared signed multiplier with registered product
module dpa_mul
    import dpa_pkg::*;
(
    input  logic                       i_clk,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output logic signed [MUL_P_W-1:0]  o_p
);

    logic signed [MUL_P_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// ----- src/dpa_div.sv -----
// restoring divider, one quotient bit per cycle
module dpa_div
    import dpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_N_W-1:0] i_dividend,
    input  logic [DIV_D_W-1:0] i_divisor,
    output logic               o_done,
    output logic [DIV_N_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W-1:0] r_dvs;
    logic [DIV_D_W:0]   rem_sh;
    logic [DIV_D_W:0]   diff;

    assign rem_sh = {r_rem, r_quo[DIV_N_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIV_N_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!diff[DIV_D_W]) begin
                r_rem <= diff[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- src/dpa_isqrt.sv -----
// digit by digit integer square root, two radicand bits per cycle
module dpa_isqrt
    import dpa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIST2_W-1:0] i_x,
    output logic               o_done,
    output logic [DIST_W-1:0]  o_root
);

    localparam int ITER  = DIST2_W / 2;
    localparam int CNT_W = $clog2(ITER + 1);
    localparam int REM_W = DIST_W + 1;

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIST2_W-1:0] r_x;
    logic [REM_W-1:0]   r_rem;
    logic [DIST_W-1:0]  r_root;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic               ge;

    assign rem_sh = {r_rem, r_x[DIST2_W-1:DIST2_W-2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(ITER);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_x;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= {r_x[DIST2_W-3:0], 2'b00};
            if (ge) begin
                r_rem  <= REM_W'(rem_sh - trial);
                r_root <= {r_root[DIST_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[DIST_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- src/doppler_pitch_and_attenuation.sv -----
// top level: sequencer around the shared multiplier, square root and divider
//
//  channel  direction  handshake                  payload
//  cfg      in         i_cfg_we                   i_cfg_idx, i_cfg_data
//  in       in         i_in_valid / o_in_stall    i_req_type .. i_far_distance
//  out      out        o_out_valid / i_out_stall  o_pitch, o_attenuation
//
// a listener update gives no result and leaves the sequencer idle
// a source query runs from its transfer to its result transfer through S_MUL1 with
// 12 multiplier steps, S_SQRT for the square root, S_MUL2 with 3 more steps, a division
// where needed (S_DIVP pitch ratio, S_DIVA normalized distance), S_MUL3 (6 steps), S_OUT
// the result is held on the out channel until its transfer; no new item is taken meanwhile
// reset is synchronous and restores the register defaults and a listener at the origin
module doppler_pitch_and_attenuation
    import dpa_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_req_type,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    input  logic signed [VEL_W-1:0] i_vel_x,
    input  logic signed [VEL_W-1:0] i_vel_y,
    input  logic signed [VEL_W-1:0] i_vel_z,
    input  logic                   i_source_doppler_on,
    input  logic [Q16_W-1:0]       i_doppler_weight,
    input  logic [POS_W-1:0]       i_near_distance,
    input  logic [POS_W-1:0]       i_far_distance,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [Q16_W-1:0]       o_pitch,
    output logic [Q16_W-1:0]       o_attenuation
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_MUL1 = 8'b00000010,
        S_SQRT = 8'b00000100,
        S_MUL2 = 8'b00001000,
        S_DIVP = 8'b00010000,
        S_DIVA = 8'b00100000,
        S_MUL3 = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    logic [3:0] r_step;

    logic               r_den_en;
    logic [Q16_W-1:0]   r_dscale;
    logic [SPEED_W-1:0] r_speed;
    logic [Q16_W-1:0]   r_ascale;

    logic signed [POS_W-1:0] r_lpos [3];
    logic signed [VEL_W-1:0] r_lvel [3];

    logic signed [D_W-1:0]   r_d  [3];
    logic signed [VEL_W-1:0] r_vs [3];
    logic                    r_src_on;
    logic [Q16_W-1:0]        r_weight;
    logic [POS_W-1:0]        r_near;
    logic [POS_W-1:0]        r_far;

    logic [DIST2_W-1:0]      r_dist2;
    logic signed [DOT_W-1:0] r_dot_s;
    logic signed [DOT_W-1:0] r_dot_l;
    logic [2*POS_W-1:0]      r_near2;
    logic [2*POS_W-1:0]      r_far2;
    logic [DIST_W-1:0]       r_dist;
    logic signed [NUM_W-1:0] r_num;
    logic signed [NUM_W-1:0] r_den;
    logic signed [E_W-1:0]   r_e;
    logic [14:0]             r_n;
    logic [31:0]             r_w;
    logic [29:0]             r_nn;
    logic [Q16_W-1:0]        r_a;
    logic signed [63:0]      r_t;
    logic [Q16_W-1:0]        r_pitch;
    logic [Q16_W-1:0]        r_atten;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] r_prod;

    logic               sqrt_start;
    logic               sqrt_done;
    logic [DIST_W-1:0]  sqrt_root;
    logic               div_start;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quo;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;

    logic               in_xfer;
    logic               bypass;
    logic               den_pos;
    logic               near_hit;
    logic               far_hit;
    logic               pitch_start;
    logic               leave_pitch;
    logic               atten_start;
    logic [NUM_W-1:0]   num_abs;
    logic [POS_W-1:0]   s_val;
    logic [POS_W-1:0]   span;
    logic signed [62:0] e_full;
    logic signed [E_W-1:0] e_sat;
    logic signed [63:0] q_full;
    logic [Q16_W-1:0]   pitch_c;
    logic [19:0]        gsh;
    logic [Q16_W-1:0]   atten_c;

    assign in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign bypass   = !r_den_en || !r_src_on || (r_dist2 == '0);
    assign den_pos  = !r_den[NUM_W-1] && (r_den != '0);
    assign near_hit = r_dist2 <= {2'b00, r_near2};
    assign far_hit  = r_dist2 >= {2'b00, r_far2};

    assign pitch_start = (r_state == S_MUL2) && (r_step == 4'd2) && !bypass && den_pos;
    assign leave_pitch = ((r_state == S_MUL2) && (r_step == 4'd2) && (bypass || !den_pos))
                      || ((r_state == S_DIVP) && div_done);
    assign atten_start = leave_pitch && !near_hit && !far_hit;
    assign div_start   = pitch_start || atten_start;
    assign sqrt_start  = (r_state == S_MUL1) && (r_step == 4'd11);

    assign num_abs = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign s_val   = r_dist[POS_W-1:0] - r_near;
    assign span    = r_far - r_near;

    always_comb begin
        if (pitch_start) begin
            div_dividend = {num_abs, 14'd0};
            div_divisor  = r_den[DIV_D_W-1:0];
        end else begin
            div_dividend = {22'd0, s_val, 15'd0};
            div_divisor  = {22'd0, span};
        end
    end

    // signed pitch offset from the quotient, saturated
    always_comb begin
        if (r_num[NUM_W-1]) begin
            e_full = -$signed({2'b00, div_quo}) - 63'sd16384;
        end else begin
            e_full = $signed({2'b00, div_quo}) - 63'sd16384;
        end
        if (e_full > 63'sd1073741824) begin
            e_sat = 32'sd1073741824;
        end else if (e_full < -63'sd1073741824) begin
            e_sat = -32'sd1073741824;
        end else begin
            e_sat = E_W'(e_full);
        end
    end

    always_comb begin
        q_full = (r_t >>> 24) + 64'sd16384;
        if (q_full < 64'sd8192) begin
            pitch_c = PITCH_MIN;
        end else if (q_full > 64'sd32768) begin
            pitch_c = PITCH_MAX;
        end else begin
            pitch_c = Q16_W'(q_full);
        end
        gsh = r_prod[31:12];
        if (near_hit) begin
            atten_c = GAIN_ONE;
        end else if (far_hit) begin
            atten_c = '0;
        end else if (gsh > 20'd32768) begin
            atten_c = GAIN_ONE;
        end else begin
            atten_c = gsh[Q16_W-1:0];
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_MUL1) begin
            case (r_step)
                4'd0: begin mul_a = MUL_A_W'(r_d[0]);  mul_b = MUL_B_W'(r_d[0]); end
                4'd1: begin mul_a = MUL_A_W'(r_d[1]);  mul_b = MUL_B_W'(r_d[1]); end
                4'd2: begin mul_a = MUL_A_W'(r_d[2]);  mul_b = MUL_B_W'(r_d[2]); end
                4'd3: begin mul_a = MUL_A_W'(r_vs[0]); mul_b = MUL_B_W'(r_d[0]); end
                4'd4: begin mul_a = MUL_A_W'(r_vs[1]); mul_b = MUL_B_W'(r_d[1]); end
                4'd5: begin mul_a = MUL_A_W'(r_vs[2]); mul_b = MUL_B_W'(r_d[2]); end
                4'd6: begin mul_a = MUL_A_W'(r_lvel[0]); mul_b = MUL_B_W'(r_d[0]); end
                4'd7: begin mul_a = MUL_A_W'(r_lvel[1]); mul_b = MUL_B_W'(r_d[1]); end
                4'd8: begin mul_a = MUL_A_W'(r_lvel[2]); mul_b = MUL_B_W'(r_d[2]); end
                4'd9: begin
                    mul_a = $signed({9'd0, r_near});
                    mul_b = $signed({3'd0, r_near});
                end
                4'd10: begin
                    mul_a = $signed({9'd0, r_far});
                    mul_b = $signed({3'd0, r_far});
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (r_state == S_MUL2) begin
            mul_a = $signed({13'd0, r_speed});
            mul_b = $signed({2'd0, r_dist});
        end else if (r_state == S_MUL3) begin
            case (r_step)
                4'd0: begin
                    mul_a = $signed({17'd0, r_dscale});
                    mul_b = $signed({11'd0, r_weight});
                end
                4'd1: begin
                    mul_a = $signed({18'd0, r_n});
                    mul_b = $signed({12'd0, r_n});
                end
                4'd2: begin
                    mul_a = MUL_A_W'(r_e);
                    mul_b = $signed({11'd0, r_w[15:0]});
                end
                4'd3: begin
                    mul_a = MUL_A_W'(r_e);
                    mul_b = $signed({11'd0, r_w[31:16]});
                end
                4'd4: begin
                    mul_a = $signed({17'd0, r_a});
                    mul_b = $signed({11'd0, r_ascale});
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    dpa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (r_prod)
    );

    dpa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_x     (r_dist2),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    dpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den_en <= 1'b1;
            r_dscale <= RST_DOPPLER_SCALE;
            r_speed  <= RST_SOUND_SPEED;
            r_ascale <= RST_ATTENUATION_SCALE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DOPPLER_ENABLE:    r_den_en <= i_cfg_data[0];
                CFG_DOPPLER_SCALE:     r_dscale <= i_cfg_data[Q16_W-1:0];
                CFG_SOUND_SPEED:       r_speed  <= i_cfg_data[SPEED_W-1:0];
                CFG_ATTENUATION_SCALE: r_ascale <= i_cfg_data[Q16_W-1:0];
                default:               r_den_en <= r_den_en;
            endcase
        end
    end

    // listener state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_lpos[i] <= '0;
                r_lvel[i] <= '0;
            end
        end else if (in_xfer && !i_req_type) begin
            r_lpos[0] <= i_pos_x;
            r_lpos[1] <= i_pos_y;
            r_lpos[2] <= i_pos_z;
            r_lvel[0] <= i_vel_x;
            r_lvel[1] <= i_vel_y;
            r_lvel[2] <= i_vel_z;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (in_xfer && i_req_type) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    if (r_step == 4'd11) begin
                        r_step  <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (sqrt_done) begin
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    if (r_step == 4'd2) begin
                        r_step <= '0;
                        if (pitch_start) begin
                            r_state <= S_DIVP;
                        end else if (atten_start) begin
                            r_state <= S_DIVA;
                        end else begin
                            r_state <= S_MUL3;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIVP: begin
                    if (div_done) begin
                        r_state <= atten_start ? S_DIVA : S_MUL3;
                    end
                end
                S_DIVA: begin
                    if (div_done) begin
                        r_state <= S_MUL3;
                    end
                end
                S_MUL3: begin
                    if (r_step == 4'd5) begin
                        r_step  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer && i_req_type) begin
            r_d[0]   <= D_W'(r_lpos[0]) - D_W'(i_pos_x);
            r_d[1]   <= D_W'(r_lpos[1]) - D_W'(i_pos_y);
            r_d[2]   <= D_W'(r_lpos[2]) - D_W'(i_pos_z);
            r_vs[0]  <= i_vel_x;
            r_vs[1]  <= i_vel_y;
            r_vs[2]  <= i_vel_z;
            r_src_on <= i_source_doppler_on;
            r_weight <= i_doppler_weight;
            r_near   <= i_near_distance;
            r_far    <= i_far_distance;
            r_dist2  <= '0;
            r_dot_s  <= '0;
            r_dot_l  <= '0;
        end
        if (r_state == S_MUL1) begin
            case (r_step)
                4'd1, 4'd2, 4'd3: r_dist2 <= r_dist2 + {2'b00, r_prod[47:0]};
                4'd4, 4'd5, 4'd6: r_dot_s <= r_dot_s + $signed(r_prod[DOT_W-1:0]);
                4'd7, 4'd8, 4'd9: r_dot_l <= r_dot_l + $signed(r_prod[DOT_W-1:0]);
                4'd10:            r_near2 <= r_prod[47:0];
                4'd11:            r_far2  <= r_prod[47:0];
                default:          r_near2 <= r_near2;
            endcase
        end
        if ((r_state == S_SQRT) && sqrt_done) begin
            r_dist <= sqrt_root;
        end
        if ((r_state == S_MUL2) && (r_step == 4'd1)) begin
            r_num <= $signed({2'b00, r_prod[44:0]}) - NUM_W'(r_dot_l);
            r_den <= $signed({2'b00, r_prod[44:0]}) - NUM_W'(r_dot_s);
        end
        if ((r_state == S_MUL2) && (r_step == 4'd2)) begin
            if (bypass) begin
                r_e <= '0;
            end else if (!den_pos) begin
                r_e <= 32'sd16384;
            end
        end
        if ((r_state == S_DIVP) && div_done) begin
            r_e <= e_sat;
        end
        if ((r_state == S_DIVA) && div_done) begin
            r_n <= div_quo[14:0];
        end
        if (r_state == S_MUL3) begin
            case (r_step)
                4'd1: r_w <= r_prod[31:0];
                4'd2: r_nn <= r_prod[29:0];
                4'd3: begin
                    r_t <= 64'(r_prod);
                    r_a <= Q16_W'(17'd32768 - {2'b00, r_nn[29:15]});
                end
                4'd4: r_t <= r_t + (64'(r_prod) <<< 16);
                4'd5: begin
                    r_pitch <= pitch_c;
                    r_atten <= atten_c;
                end
                default: r_w <= r_w;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_pitch       = r_pitch;
    assign o_attenuation = r_atten;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the doppler pitch and attenuation block
`timescale 1ns / 1ps

module tb_top;
    import dpa_pkg::*;

    localparam logic REQ_LISTENER = 1'b0;
    localparam logic REQ_QUERY    = 1'b1;
    localparam int   IDLE_LIMIT   = 4000;

    typedef struct {
        logic                    req_type;
        logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
        logic signed [VEL_W-1:0] vel_x, vel_y, vel_z;
        logic                    src_on;
        logic [Q16_W-1:0]        weight;
        logic [POS_W-1:0]        near_d, far_d;
    } t_req;

    typedef struct {
        logic [Q16_W-1:0] pitch;
        logic [Q16_W-1:0] atten;
    } t_result;

    typedef struct {
        t_req             req;
        bit               typed;
        logic [Q16_W-1:0] pitch;
        logic [Q16_W-1:0] atten;
    } t_row;

    typedef struct {
        logic               en;
        logic [Q16_W-1:0]   dscale;
        logic [SPEED_W-1:0] speed;
        logic [Q16_W-1:0]   ascale;
        int                 items;
    } t_setting;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic                   i_req_type = 1'b0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [VEL_W-1:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic                   i_source_doppler_on = 1'b0;
    logic [Q16_W-1:0]       i_doppler_weight = '0;
    logic [POS_W-1:0]       i_near_distance = '0;
    logic [POS_W-1:0]       i_far_distance = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [Q16_W-1:0]       o_pitch;
    logic [Q16_W-1:0]       o_attenuation;

    doppler_pitch_and_attenuation u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic               mdl_en;
    logic [Q16_W-1:0]   mdl_dscale;
    logic [SPEED_W-1:0] mdl_speed;
    logic [Q16_W-1:0]   mdl_ascale;
    longint             lst_pos[3];
    longint             lst_vel[3];

    t_result pending_results[$];
    int      errors = 0;
    bit      quiet = 1'b0;
    int      idle_cycles = 0;

    task automatic report(string what, int exp_v, int got_v);
        $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned dist_sq(t_req r);
        longint dx, dy, dz;
        dx = lst_pos[0] - longint'(r.pos_x);
        dy = lst_pos[1] - longint'(r.pos_y);
        dz = lst_pos[2] - longint'(r.pos_z);
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // listener updates change state; queries give pitch and gain
    function automatic bit pitch_and_gain(t_req r, output t_result res);
        longint d[3];
        longint dot_s, dot_l, cd, num, den, ratio, e, q;
        longint unsigned dist2, dist_v, nr, fr, s, span, n, a, g, w;
        res = '{default: '0};
        if (r.req_type == REQ_LISTENER) begin
            lst_pos = '{longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z)};
            lst_vel = '{longint'(r.vel_x), longint'(r.vel_y), longint'(r.vel_z)};
            return 1'b0;
        end
        d[0] = lst_pos[0] - longint'(r.pos_x);
        d[1] = lst_pos[1] - longint'(r.pos_y);
        d[2] = lst_pos[2] - longint'(r.pos_z);
        dist2 = dist_sq(r);
        dist_v = int_sqrt(dist2);
        if (!mdl_en || !r.src_on || dist2 == 0) begin
            q = 16384;
        end else begin
            dot_s = longint'(r.vel_x) * d[0] + longint'(r.vel_y) * d[1]
                  + longint'(r.vel_z) * d[2];
            dot_l = lst_vel[0] * d[0] + lst_vel[1] * d[1] + lst_vel[2] * d[2];
            cd = longint'({44'd0, mdl_speed}) * longint'(dist_v);
            num = cd - dot_l;
            den = cd - dot_s;
            if (den <= 0) ratio = 32768;
            else ratio = (num * 16384) / den;
            e = ratio - 16384;
            if (e > (64'sd1 <<< 30)) e = 64'sd1 <<< 30;
            if (e < -(64'sd1 <<< 30)) e = -(64'sd1 <<< 30);
            w = longint'({48'd0, mdl_dscale}) * longint'({48'd0, r.weight});
            q = 16384 + ((e * longint'(w)) >>> 24);
            if (q < 8192) q = 8192;
            if (q > 32768) q = 32768;
        end
        res.pitch = q[15:0];
        nr = {40'd0, r.near_d};
        fr = {40'd0, r.far_d};
        if (dist2 <= nr * nr) begin
            g = 32768;
        end else if (dist2 >= fr * fr) begin
            g = 0;
        end else begin
            s = dist_v - nr;
            span = fr - nr;
            n = (s << 15) / span;
            if (n > 32768) n = 32768;
            a = 32768 - ((n * n) >> 15);
            g = (a * {48'd0, mdl_ascale}) >> 12;
            if (g > 32768) g = 32768;
        end
        res.atten = g[15:0];
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // out side stall pattern
    int stall_hold = 0;
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                     : $urandom_range(10, 60);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected result, pitch", 0, o_pitch);
            end else begin
                want = pending_results.pop_front();
                if (o_pitch !== want.pitch) report("pitch", want.pitch, o_pitch);
                if (o_attenuation !== want.atten)
                    report("attenuation", want.atten, o_attenuation);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(t_req r, bit typed, t_result typed_res);
        int gap;
        t_result res;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= r.req_type;
        i_pos_x <= r.pos_x;
        i_pos_y <= r.pos_y;
        i_pos_z <= r.pos_z;
        i_vel_x <= r.vel_x;
        i_vel_y <= r.vel_y;
        i_vel_z <= r.vel_z;
        i_source_doppler_on <= r.src_on;
        i_doppler_weight <= r.weight;
        i_near_distance <= r.near_d;
        i_far_distance <= r.far_d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (pitch_and_gain(r, res))
            pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_setting(t_setting st);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_DOPPLER_ENABLE;
        i_cfg_data <= {19'd0, st.en};
        @(posedge i_clk);
        i_cfg_idx <= CFG_DOPPLER_SCALE;
        i_cfg_data <= {4'd0, st.dscale};
        @(posedge i_clk);
        i_cfg_idx <= CFG_SOUND_SPEED;
        i_cfg_data <= st.speed;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ATTENUATION_SCALE;
        i_cfg_data <= {4'd0, st.ascale};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_en = st.en;
        mdl_dscale = st.dscale;
        mdl_speed = st.speed;
        mdl_ascale = st.ascale;
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos(longint centre);
        int pick;
        longint v;
        pick = $urandom_range(0, 9);
        if (pick < 6) v = centre + longint'($urandom_range(0, 40000)) - 20000;
        else if (pick < 7) v = ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
        else return POS_W'($urandom);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[POS_W-1:0];
    endfunction

    function automatic logic signed [VEL_W-1:0] rand_vel();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return VEL_W'(int'($urandom_range(0, 8000)) - 4000);
        if (pick < 7) return ($urandom_range(0, 1) != 0) ? VEL_W'(262143) : VEL_W'(-262144);
        return VEL_W'($urandom);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        longint unsigned dst;
        r.req_type = ($urandom_range(0, 3) == 0) ? REQ_LISTENER : REQ_QUERY;
        r.pos_x = rand_pos(lst_pos[0]);
        r.pos_y = rand_pos(lst_pos[1]);
        r.pos_z = rand_pos(lst_pos[2]);
        r.vel_x = rand_vel();
        r.vel_y = rand_vel();
        r.vel_z = rand_vel();
        r.src_on = ($urandom_range(0, 7) != 0);
        r.weight = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        dst = int_sqrt(dist_sq(r));
        if (dst > 16777215) dst = 16777215;
        if ($urandom_range(0, 9) < 7) begin
            r.near_d = POS_W'($urandom_range(0, int'(dst)));
            r.far_d = (dst + $urandom_range(0, int'(dst) + 1) > 16777215) ? 24'hFFFFFF
                    : 24'(dst + $urandom_range(0, int'(dst) + 1));
        end else begin
            r.near_d = POS_W'($urandom);
            r.far_d = POS_W'($urandom);
        end
        return r;
    endfunction

    function automatic t_row row(logic rt, int px, int py, int pz, int vx, int vy, int vz,
                                 logic on, int wt, int nd, int fd,
                                 bit typed, int p, int a);
        t_row rw;
        rw.req = '{rt, px[23:0], py[23:0], pz[23:0], vx[18:0], vy[18:0], vz[18:0],
                   on, wt[15:0], nd[23:0], fd[23:0]};
        rw.typed = typed;
        rw.pitch = p[15:0];
        rw.atten = a[15:0];
        return rw;
    endfunction

    t_row     directed[$];
    t_setting settings[$];

    initial begin
        t_result tr;
        directed = '{
            row(REQ_QUERY, 0, 0, 0, 0, 0, 0, 1, 4096, 0, 0, 1, 16384, 32768),
            row(REQ_LISTENER, 8388607, 8388607, 8388607, 262143, 262143, 262143,
                0, 0, 0, 0, 0, 0, 0),
            row(REQ_QUERY, -8388608, -8388608, -8388608, -262144, -262144, -262144,
                1, 65535, 0, 16777215, 0, 0, 0),
            row(REQ_QUERY, 8388607, 8388607, 8388607, 5, 5, 5, 1, 4096, 0, 10,
                1, 16384, 32768),
            row(REQ_QUERY, 0, 0, 0, 100, 0, 0, 0, 4096, 16777215, 16777215,
                1, 16384, 32768),
            row(REQ_QUERY, 0, 0, 0, 262143, 262143, 262143, 1, 65535, 5, 3, 0, 0, 0),
            row(REQ_LISTENER, 0, 0, 0, 0, 0, 0, 1, 65535, 16777215, 16777215, 0, 0, 0),
            row(REQ_QUERY, 1000, 0, 0, -262144, 0, 0, 1, 4096, 0, 2000, 1, 32768, 24576),
            row(REQ_QUERY, 1000, 0, 0, 0, 0, 0, 1, 0, 1000, 2000, 1, 16384, 32768),
            row(REQ_QUERY, 1, 0, 0, 262143, 0, 0, 1, 65535, 0, 16777215, 0, 0, 0),
            row(REQ_QUERY, 0, -300, 400, 0, 20000, -20000, 1, 8192, 100, 900, 0, 0, 0),
            row(REQ_LISTENER, -5000, 2000, 700, 30000, -1200, 50, 0, 0, 0, 0, 0, 0, 0),
            row(REQ_QUERY, 5000, 2000, 700, -30000, 0, 0, 1, 4096, 0, 20000, 0, 0, 0),
            row(REQ_QUERY, -5000, 2000, 701, 0, 0, 0, 1, 4096, 0, 1, 0, 0, 0),
            row(REQ_QUERY, -8388608, 8388607, -8388608, 262143, -262144, 262143,
                1, 12288, 1000, 999, 0, 0, 0)
        };
        settings = '{
            '{1'b1, 16'd4096, 20'd34300, 16'd4096, 450},
            '{1'b1, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 250},
            '{1'b0, 16'd4096, 20'd34300, 16'd4096, 150},
            '{1'b1, 16'd0, 20'd1, 16'd0, 250},
            '{1'b1, 16'($urandom), 20'($urandom_range(1, 100000)), 16'($urandom), 300},
            '{1'b1, 16'd4096, 20'd0, 16'd8192, 150},
            '{1'b1, 16'd12345, 20'd340, 16'd4096, 300}
        };
        tr = '{default: '0};
        mdl_en = 1'b1;
        mdl_dscale = 16'd4096;
        mdl_speed = 20'd34300;
        mdl_ascale = 16'd4096;
        lst_pos = '{0, 0, 0};
        lst_vel = '{0, 0, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs on reset defaults
        foreach (directed[k]) begin
            tr.pitch = directed[k].pitch;
            tr.atten = directed[k].atten;
            send(directed[k].req, directed[k].typed, tr);
        end
        drain();

        foreach (settings[k]) begin
            apply_setting(settings[k]);
            quiet = (k == 1);
            for (int j = 0; j < settings[k].items; j++)
                send(rand_req(), 1'b0, tr);
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
